/* hdl/cshm_pkg.sv */
// ----------------------------------------------------------------------------
// cshm_pkg: shared types and constants
// Sizes, field widths, command and register codes for the closest-string
// scoring block.
// ----------------------------------------------------------------------------
package cshm_pkg;

	localparam int ALPHABET_MAX = 32;
	localparam int STRINGS_MAX  = 64;
	localparam int LENGTH_MAX   = 256;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int ROW_W    = 6;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 8;
	localparam int ASIZE_W  = 6;
	localparam int SCOUNT_W = 7;
	localparam int SLEN_W   = 9;
	localparam int CNT_W    = 9;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 9;

	localparam int ALPHA_IW = (ALPHABET_MAX > 1) ? $clog2(ALPHABET_MAX) : 1;
	localparam int STR_IW   = (STRINGS_MAX > 1) ? $clog2(STRINGS_MAX) : 1;
	localparam int REF_AW   = ((STRINGS_MAX * LENGTH_MAX) > 1) ?
		$clog2(STRINGS_MAX * LENGTH_MAX) : 1;

	localparam logic [CNT_W-1:0] COUNTER_TOP = '1;

	localparam logic [CMD_W-1:0] CMD_LETTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REF    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SYMBOL = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_ALPHA_SIZE   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_STRING_COUNT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_STRING_LEN   = 2'd2;

	// request to the distance counter bank
	typedef struct packed {
		logic [STR_IW-1:0] rd_addr;
		logic              wr_en;
		logic [STR_IW-1:0] wr_addr;
		logic [CNT_W-1:0]  wr_data;
		logic              clear;
	} cnt_req_t;

endpackage

/* hdl/cshm_counter_bank.sv */
// ----------------------------------------------------------------------------
// cshm_counter_bank: per-string distance counters
// One write and one registered read per cycle; per-entry valid bits make
// unwritten or cleared entries read as zero, and clear drops them all at once.
// ----------------------------------------------------------------------------
module cshm_counter_bank
	import cshm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cnt_req_t         req,
	output logic [CNT_W-1:0] rd_data
);

	logic [CNT_W-1:0] mem [STRINGS_MAX];
	logic [STRINGS_MAX-1:0] vld_q;
	logic [CNT_W-1:0] rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_q <= mem[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[req.rd_addr];
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* hdl/closest_string_max_hamming_core.sv */
// ----------------------------------------------------------------------------
// closest_string_max_hamming_core: closest-string objective scorer
// Scores a candidate string by its largest Hamming distance to the stored
// reference strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, row, position, value.
//   Letter and reference loads never stall the input; in_ready stays high.
//   A candidate symbol walks the active reference strings through one shared
//   compare/increment unit, one string per cycle, then ST_DRAIN (and ST_EMIT
//   for the result word), in_ready low meanwhile. The walk length is set
//   by the single read port of the reference memory and counter bank.
//   The symbol at the last position (effective length minus one) also emits
//   one word on the output channel (out_valid/out_ready): max_distance and
//   bad_symbol, then clears the counters and the flag. The output register
//   holds a finished word while the next items are accepted; only a second
//   finished word waits for out_ready.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write only while idle.
//   Reset: registers to 4 / 64 / 256, counters and flag zero, output empty.
//   Alphabet and reference memories are undefined until loaded; no clear pass.
// ----------------------------------------------------------------------------
module closest_string_max_hamming_core
	import cshm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  command,
	input  logic [ROW_W-1:0]  row,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CNT_W-1:0]  max_distance,
	output logic              bad_symbol,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [ASIZE_W-1:0]  alpha_size_q;
	logic [SCOUNT_W-1:0] str_count_q;
	logic [SLEN_W-1:0]   str_len_q;

	logic [ASIZE_W-1:0]  eff_alpha;
	logic [SCOUNT_W-1:0] eff_count;
	logic [SLEN_W-1:0]   eff_len;
	logic [SLEN_W-1:0]   len_clamp;

	logic [VAL_W-1:0] alpha_mem [ALPHABET_MAX];
	logic [VAL_W-1:0] ref_mem [STRINGS_MAX*LENGTH_MAX];
	logic [VAL_W-1:0] ref_rd_q;
	logic [REF_AW-1:0] ref_raddr;
	logic [REF_AW-1:0] ref_waddr;

	logic accept;
	logic sym_go;
	logic sym_bad;

	logic [VAL_W-1:0]  letter_q;
	logic              sym_bad_q;
	logic              last_q;
	logic [POS_W-1:0]  pos_q;
	logic [STR_IW:0]   count_q;
	logic [STR_IW-1:0] idx_q;
	logic              walk_end;

	logic              walk_s1;
	logic [STR_IW-1:0] idx_s1;

	logic              bad_flag_q;
	logic [CNT_W-1:0]  best_q;
	logic [CNT_W-1:0]  cnt_rd_data;
	logic [CNT_W-1:0]  cnt_cur;
	logic [CNT_W-1:0]  cnt_new;
	logic              mismatch;
	logic              emit_go;

	logic              out_valid_q;
	logic [CNT_W-1:0]  max_distance_q;
	logic              bad_symbol_q;

	cnt_req_t cnt_req;

	// effective register values
	always_comb begin
		eff_alpha = (int'(alpha_size_q) > ALPHABET_MAX) ?
			ASIZE_W'(ALPHABET_MAX) : alpha_size_q;
		eff_count = (int'(str_count_q) > STRINGS_MAX) ?
			SCOUNT_W'(STRINGS_MAX) : str_count_q;
		len_clamp = (int'(str_len_q) > LENGTH_MAX) ? SLEN_W'(LENGTH_MAX) : str_len_q;
		eff_len   = (len_clamp == '0) ? SLEN_W'(1) : len_clamp;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign sym_go    = accept && (command == CMD_SYMBOL) && (SLEN_W'(position) < eff_len);
	assign sym_bad   = value >= VAL_W'(eff_alpha);
	assign walk_end  = ({1'b0, idx_q} + 1'b1) == count_q;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign ref_raddr = REF_AW'(int'(idx_q) * LENGTH_MAX + int'(pos_q));
	assign ref_waddr = REF_AW'(int'(row) * LENGTH_MAX + int'(position));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_size_q <= ASIZE_W'(4);
			str_count_q  <= SCOUNT_W'(64);
			str_len_q    <= SLEN_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ALPHA_SIZE:   alpha_size_q <= cfg_data[ASIZE_W-1:0];
				CFG_STRING_COUNT: str_count_q  <= cfg_data[SCOUNT_W-1:0];
				CFG_STRING_LEN:   str_len_q    <= cfg_data[SLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// alphabet and reference memories
	always_ff @(posedge clk) begin
		if (accept && (command == CMD_LETTER) && (int'(row) < ALPHABET_MAX)) begin
			alpha_mem[row[ALPHA_IW-1:0]] <= value;
		end
		if (accept && (command == CMD_REF) && (int'(row) < STRINGS_MAX)
				&& (int'(position) < LENGTH_MAX)) begin
			ref_mem[ref_waddr] <= value;
		end
		ref_rd_q <= ref_mem[ref_raddr];
	end

	// symbol context, captured at accept
	always_ff @(posedge clk) begin
		if (sym_go) begin
			letter_q  <= alpha_mem[value[ALPHA_IW-1:0]];
			sym_bad_q <= sym_bad;
			last_q    <= ({1'b0, position} == (eff_len - 1'b1));
			pos_q     <= position;
			count_q   <= (STR_IW+1)'(eff_count);
		end
		idx_s1 <= idx_q;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sym_go) begin
					state_d = (eff_count == '0) ? ST_DRAIN : ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			walk_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_s1 <= (state_q == ST_WALK);
			if (sym_go) begin
				idx_q <= '0;
			end else if (state_q == ST_WALK) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// shared compare / saturating increment
	assign cnt_cur  = walk_s1 ? cnt_rd_data : '0;
	assign mismatch = sym_bad_q || (ref_rd_q != letter_q);
	assign cnt_new  = (mismatch && (cnt_cur != COUNTER_TOP)) ? cnt_cur + 1'b1 : cnt_cur;

	always_comb begin
		cnt_req.rd_addr = idx_q;
		cnt_req.wr_en   = walk_s1;
		cnt_req.wr_addr = idx_s1;
		cnt_req.wr_data = cnt_new;
		cnt_req.clear   = emit_go;
	end

	cshm_counter_bank u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_data (cnt_rd_data)
	);

	// running max and bad flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_flag_q <= 1'b0;
			best_q     <= '0;
		end else begin
			if (sym_go) begin
				best_q <= '0;
			end else if (walk_s1 && (cnt_new > best_q)) begin
				best_q <= cnt_new;
			end
			if (emit_go) begin
				bad_flag_q <= 1'b0;
			end else if (sym_go && sym_bad) begin
				bad_flag_q <= 1'b1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			max_distance_q <= best_q;
			bad_symbol_q   <= bad_flag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign max_distance = max_distance_q;
	assign bad_symbol   = bad_symbol_q;

endmodule

/* hdl/cshm_checker.sv */
// ----------------------------------------------------------------------------
// cshm_checker: port-level checks
// Watches the top level's input and output channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module cshm_checker
	import cshm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [CMD_W-1:0] command,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CNT_W-1:0] max_distance,
	input logic             bad_symbol
);

	// a word is held until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the word was taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(max_distance) && $stable(bad_symbol))
		else $error("output word changed while stalled");

	// loads and unused commands never stall the input
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command != CMD_SYMBOL) |=> in_ready)
		else $error("input stalled after a load");

	// a result word only comes out of a symbol walk
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared while idle");

endmodule

bind closest_string_max_hamming_core cshm_checker u_cshm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.command      (command),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.max_distance (max_distance),
	.bad_symbol   (bad_symbol)
);
